[hdl/fcbu_pkg.sv]
// Package: shared constants and command/status types for the camera basis unit.
`timescale 1ns / 1ps
package fcbu_pkg;
    localparam logic [1:0] OP_ROTATE  = 2'd0;
    localparam logic [1:0] OP_MOVE    = 2'd1;
    localparam logic [1:0] OP_SETPOS  = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam int CORDIC_STAGES = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam longint TENTH_RAD_T32 = 64'd68356528;

    localparam int REG_POS_X = 0;
    localparam int REG_POS_Y = 1;
    localparam int REG_POS_Z = 2;
    localparam int REG_HEAD  = 3;
    localparam int REG_ELEV  = 4;

    function automatic logic signed [33:0] atan_of(input logic [4:0] i);
        case (i)
            5'd0: atan_of = 34'sh20000000;  5'd1: atan_of = 34'sh12E4051D;
            5'd2: atan_of = 34'sh09FB385B;  5'd3: atan_of = 34'sh051111D4;
            5'd4: atan_of = 34'sh028B0D43;  5'd5: atan_of = 34'sh0145D7E1;
            5'd6: atan_of = 34'sh00A2F61E;  5'd7: atan_of = 34'sh00517C55;
            5'd8: atan_of = 34'sh0028BE53;  5'd9: atan_of = 34'sh00145F2F;
            5'd10: atan_of = 34'sh000A2F98; 5'd11: atan_of = 34'sh000517CC;
            5'd12: atan_of = 34'sh00028BE6; 5'd13: atan_of = 34'sh000145F3;
            5'd14: atan_of = 34'sh0000A2F9; 5'd15: atan_of = 34'sh0000517C;
            5'd16: atan_of = 34'sh000028BE; 5'd17: atan_of = 34'sh0000145F;
            5'd18: atan_of = 34'sh00000A2F; 5'd19: atan_of = 34'sh00000517;
            5'd20: atan_of = 34'sh0000028B; 5'd21: atan_of = 34'sh00000145;
            5'd22: atan_of = 34'sh000000A2; 5'd23: atan_of = 34'sh00000051;
            default: atan_of = 34'sh0;
        endcase
    endfunction

    typedef struct packed {
        logic start_item;   // latch item, update angles/position
        logic cordic_start; // start a sin/cos pass
        logic cordic_sel;   // 0 heading, 1 elevation
        logic cordic_step;  // one CORDIC iteration
        logic cordic_done;  // store pass result
        logic [2:0] prod;   // product/finish step index
        logic prod_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
    } t_status;
endpackage

[hdl/fcbu_ctrl.sv]
// Controller: sequences angle update, two CORDIC passes, products and output.
`timescale 1ns / 1ps
module fcbu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_free,
    input  fcbu_pkg::t_status i_status,
    output logic            o_busy,
    output fcbu_pkg::t_cmd  o_cmd
);
    import fcbu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_CSTART = 3'd1, S_CRUN = 3'd2,
                           S_PROD = 3'd3, S_OUT = 3'd4;

    logic [2:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.cordic_sel = r_sel;
        o_cmd.prod = r_cnt[2:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.start_item = 1'b1;
                    n_sel = 1'b0;
                    n_state = S_CSTART;
                end
            end
            S_CSTART: begin
                // set-position skips all maths and repeats the last result
                if (i_status.op == OP_SETPOS) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.cordic_start = 1'b1;
                    n_cnt = '0;
                    n_state = S_CRUN;
                end
            end
            S_CRUN: begin
                o_cmd.cordic_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(CORDIC_STAGES - 1)) begin
                    n_cnt = '0;
                    if (r_sel) begin
                        n_state = S_PROD;
                    end else begin
                        n_sel = 1'b1;
                        n_state = S_CSTART;
                    end
                end
            end
            S_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd4) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.cordic_done = (r_state == S_CRUN) && (r_cnt == 5'(CORDIC_STAGES - 1));
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

[hdl/fcbu_datapath.sv]
// Datapath: camera state, shared CORDIC, product unit and result registers.
`timescale 1ns / 1ps
module fcbu_datapath #(
    parameter int ANGLE_BITS     = 24,
    parameter int POS_FRAC_BITS  = 16,
    parameter int UNIT_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fcbu_pkg::t_cmd                i_cmd,
    output fcbu_pkg::t_status             o_status,
    input  logic [1:0]                    i_op,
    input  logic signed [19:0]            i_hstep,
    input  logic signed [19:0]            i_estep,
    input  logic signed [31:0]            i_vec [3],
    input  logic signed [31:0]            i_start_pos [3],
    input  logic [ANGLE_BITS-1:0]         i_start_head,
    input  logic [ANGLE_BITS-1:0]         i_start_elev,
    output logic signed [31:0]            o_target [3],
    output logic signed [UNIT_FRAC_BITS+1:0] o_unit [9]
);
    import fcbu_pkg::*;

    localparam int UW = UNIT_FRAC_BITS + 2;
    localparam longint LIM_OFF = ((TENTH_RAD_T32 << ANGLE_BITS) + (64'd1 << 31)) >>> 32;
    localparam longint LIM = (64'd1 << (ANGLE_BITS - 2)) - LIM_OFF;
    localparam logic signed [ANGLE_BITS+1:0] LIM_P = (ANGLE_BITS+2)'(LIM);
    localparam logic signed [ANGLE_BITS+1:0] LIM_N = -LIM_P;
    localparam longint ONE_U = 64'd1 << UNIT_FRAC_BITS;
    // reciprocal of 360 scaled by 2^(ANGLE_BITS+19), exact for every 20-bit step
    localparam int RW = ANGLE_BITS + 31;
    localparam int DW = 2 * ANGLE_BITS + 21;
    localparam longint DEG_RECIP = ((64'd1 << (ANGLE_BITS + 19)) + 64'd359) / 64'd360;
    localparam longint DEG_BIAS = 180 * DEG_RECIP;

    logic signed [31:0] r_pos [3];
    logic [ANGLE_BITS-1:0] r_head;
    logic signed [ANGLE_BITS-1:0] r_elev;
    logic [1:0] r_op;
    logic signed [31:0] r_tgt [3];
    logic signed [UW-1:0] r_unit [9];

    // CORDIC state
    logic signed [33:0] r_x, r_y, r_z;
    logic r_flip;
    logic [4:0] r_i;
    logic signed [33:0] r_sy, r_cy, r_sp, r_cp;
    logic signed [67:0] r_pr;
    logic signed [67:0] r_pr0, r_pr2, r_pr6, r_pr8;

    // degree to binary angle: (|s| << (A-10) + 180) / 360 as a reciprocal product
    function automatic logic signed [ANGLE_BITS+1:0] step_to_angle(input logic signed [19:0] s);
        logic [19:0] mag;
        logic [RW-1:0] prd;
        logic [DW-1:0] sc;
        logic [ANGLE_BITS+1:0] q;
        mag = s[19] ? 20'(-s) : 20'(s);
        prd = RW'(mag) * RW'(DEG_RECIP);
        sc = (DW'(prd) << (ANGLE_BITS - 10)) + DW'(DEG_BIAS);
        q = (ANGLE_BITS+2)'(sc >> (ANGLE_BITS + 19));
        step_to_angle = s[19] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [ANGLE_BITS-1:0] clamp_elev(input logic signed [ANGLE_BITS+1:0] v);
        if (v > LIM_P) clamp_elev = ANGLE_BITS'(LIM_P);
        else if (v < LIM_N) clamp_elev = ANGLE_BITS'(LIM_N);
        else clamp_elev = ANGLE_BITS'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) sat32 = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = 32'(v);
    endfunction

    function automatic logic signed [UW-1:0] to_unit(input logic signed [67:0] v, input int sh);
        logic signed [67:0] r;
        r = (v + (68'sd1 <<< (sh - 1))) >>> sh;
        if (r > 68'(ONE_U)) to_unit = UW'(ONE_U);
        else if (r < -68'(ONE_U)) to_unit = UW'(-ONE_U);
        else to_unit = UW'(r);
    endfunction

    function automatic logic signed [33:0] to_pos(input logic signed [67:0] v, input int sh);
        to_pos = 34'((v + (68'sd1 <<< (sh - 1))) >>> sh);
    endfunction

    logic [31:0] a32;
    logic [31:0] a_fl;
    logic        flip;
    always_comb begin
        a32 = i_cmd.cordic_sel ? (32'(r_elev) << (32 - ANGLE_BITS))
                               : (32'(r_head) << (32 - ANGLE_BITS));
        flip = (a32[31:30] == 2'd1) || (a32[31:30] == 2'd2);
        a_fl = flip ? (a32 + 32'h80000000) : a32;
    end

    logic signed [33:0] cx, cy_n, cz;
    always_comb begin
        logic signed [33:0] dx, dy;
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        if (!r_z[33]) begin
            cx = r_x - dx; cy_n = r_y + dy; cz = r_z - atan_of(r_i);
        end else begin
            cx = r_x + dx; cy_n = r_y - dy; cz = r_z + atan_of(r_i);
        end
    end

    // one multiplier, operands picked by product step
    logic signed [33:0] ma, mb;
    always_comb begin
        case (i_cmd.prod)
            3'd0: begin ma = r_cp; mb = r_sy; end
            3'd1: begin ma = r_cp; mb = r_cy; end
            3'd2: begin ma = r_sp; mb = r_sy; end
            3'd3: begin ma = r_sp; mb = r_cy; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    logic signed [33:0] r_px [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_tgt[k] <= '0;
            end
            for (int k = 0; k < 9; k++) r_unit[k] <= '0;
            r_head <= '0;
            r_elev <= '0;
            r_op   <= OP_ROTATE;
        end else begin
            if (i_cmd.start_item) begin
                r_op <= i_op;
                unique case (i_op)
                    OP_ROTATE: begin
                        r_head <= r_head + ANGLE_BITS'(step_to_angle(i_hstep));
                        r_elev <= clamp_elev((ANGLE_BITS+2)'(r_elev)
                                             + (ANGLE_BITS+2)'(step_to_angle(i_estep)));
                    end
                    OP_MOVE: begin
                        for (int k = 0; k < 3; k++)
                            r_pos[k] <= sat32(34'(r_pos[k]) + 34'(i_vec[k]));
                    end
                    OP_SETPOS: begin
                        for (int k = 0; k < 3; k++) r_pos[k] <= i_vec[k];
                    end
                    OP_RESTART: begin
                        for (int k = 0; k < 3; k++) r_pos[k] <= i_start_pos[k];
                        r_head <= i_start_head;
                        r_elev <= clamp_elev((ANGLE_BITS+2)'($signed(i_start_elev)));
                    end
                    default: ;
                endcase
            end
            if (i_cmd.prod_en && i_cmd.prod == 3'd4) begin
                r_px[0] <= to_pos(r_pr0, 60 - POS_FRAC_BITS);
                r_px[1] <= to_pos(68'(r_sp), 30 - POS_FRAC_BITS);
                r_px[2] <= to_pos(r_pr2, 60 - POS_FRAC_BITS);
            end
            // results change only once the previous one has left
            if (i_cmd.out_load && r_op != OP_SETPOS) begin
                r_unit[0] <= to_unit(r_pr0, 60 - UNIT_FRAC_BITS);
                r_unit[1] <= to_unit(68'(r_sp), 30 - UNIT_FRAC_BITS);
                r_unit[2] <= to_unit(r_pr2, 60 - UNIT_FRAC_BITS);
                r_unit[3] <= to_unit(-68'(r_cy), 30 - UNIT_FRAC_BITS);
                r_unit[4] <= '0;
                r_unit[5] <= to_unit(68'(r_sy), 30 - UNIT_FRAC_BITS);
                r_unit[6] <= to_unit(-r_pr6, 60 - UNIT_FRAC_BITS);
                r_unit[7] <= to_unit(68'(r_cp), 30 - UNIT_FRAC_BITS);
                r_unit[8] <= to_unit(-r_pr8, 60 - UNIT_FRAC_BITS);
                for (int k = 0; k < 3; k++)
                    r_tgt[k] <= sat32(34'(r_pos[k]) + r_px[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_start) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= 34'($signed(a_fl));
            r_flip <= flip;
            r_i <= '0;
        end else if (i_cmd.cordic_step) begin
            r_x <= cx;
            r_y <= cy_n;
            r_z <= cz;
            r_i <= r_i + 5'd1;
        end
        if (i_cmd.cordic_done) begin
            if (i_cmd.cordic_sel) begin
                r_sp <= r_flip ? -cy_n : cy_n;
                r_cp <= r_flip ? -cx : cx;
            end else begin
                r_sy <= r_flip ? -cy_n : cy_n;
                r_cy <= r_flip ? -cx : cx;
            end
        end
        if (i_cmd.prod_en) begin
            r_pr <= ma * mb;
            case (i_cmd.prod)
                3'd1: r_pr0 <= r_pr;
                3'd2: r_pr2 <= r_pr;
                3'd3: r_pr6 <= r_pr;
                3'd4: r_pr8 <= r_pr;
                default: ;
            endcase
        end
    end

    assign o_status.op = r_op;
    assign o_target = r_tgt;
    assign o_unit   = r_unit;
endmodule

[hdl/fps_camera_basis_update_top.sv]
// Top level: stream and register ports around the camera basis controller and datapath.
`timescale 1ns / 1ps
// First-person camera basis unit.
// Input stream (s_axis): one command per transfer; tdata packs operation,
// heading_step, elevation_step, vec_x, vec_y, vec_z from bit 0 up.
// Output stream (m_axis): one result per command; tdata packs target_x/y/z
// then look, right and up vectors (x, y, z each), Q1.16 fields 18 bits.
// Configuration: APB registers at 4*i: start position x/y/z, start heading,
// start elevation. Write only while idle.
// Sequencing: one item at a time. A rotate, move or restart runs two
// 24-iteration passes of the shared CORDIC unit, then five product steps
// on the single multiplier. A set-position item skips the maths
// and repeats the previous result. s_axis_tready is high only while
// idle. The result sits in an output register; if the receiver stalls, the
// block holds it, may take the next command, and keeps that result back
// until the held one has been transferred.
// Reset clears position, angles, the last result and the start and valid registers.
module fps_camera_basis_update_top #(
    parameter int ANGLE_BITS     = 24,
    parameter int POS_FRAC_BITS  = 16,
    parameter int UNIT_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], heading_step[21:2], elevation_step[41:22], vec_x, vec_y, vec_z
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // target_x, target_y, target_z, look xyz, right xyz, up xyz
    output logic [96+9*(UNIT_FRAC_BITS+2)+7-((96+9*(UNIT_FRAC_BITS+2)+7)%8)-1:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import fcbu_pkg::*;

    localparam int UW = UNIT_FRAC_BITS + 2;

    logic signed [31:0] r_spos [3];
    logic [ANGLE_BITS-1:0] r_shead, r_selev;
    logic r_ovalid;
    logic busy;
    t_cmd cmd;
    t_status status;
    logic signed [31:0] tgt [3];
    logic signed [UW-1:0] unit [9];
    logic signed [31:0] vec [3];

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_spos[k] <= '0;
            r_shead <= '0;
            r_selev <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (32'(paddr[4:2]))
                REG_POS_X: r_spos[0] <= pwdata;
                REG_POS_Y: r_spos[1] <= pwdata;
                REG_POS_Z: r_spos[2] <= pwdata;
                REG_HEAD:  r_shead <= ANGLE_BITS'(pwdata);
                REG_ELEV:  r_selev <= ANGLE_BITS'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (32'(paddr[4:2]))
            REG_POS_X: prdata = r_spos[0];
            REG_POS_Y: prdata = r_spos[1];
            REG_POS_Z: prdata = r_spos[2];
            REG_HEAD:  prdata = 32'(r_shead);
            REG_ELEV:  prdata = 32'(r_selev);
            default:   prdata = '0;
        endcase
    end

    assign s_axis_tready = !busy;
    assign vec[0] = s_axis_tdata[73:42];
    assign vec[1] = s_axis_tdata[105:74];
    assign vec[2] = s_axis_tdata[137:106];

    fcbu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_free(!r_ovalid || m_axis_tready),
        .i_status(status), .o_busy(busy), .o_cmd(cmd)
    );

    fcbu_datapath #(
        .ANGLE_BITS(ANGLE_BITS), .POS_FRAC_BITS(POS_FRAC_BITS),
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_op(s_axis_tdata[1:0]), .i_hstep(s_axis_tdata[21:2]),
        .i_estep(s_axis_tdata[41:22]), .i_vec(vec),
        .i_start_pos(r_spos), .i_start_head(r_shead), .i_start_elev(r_selev),
        .o_target(tgt), .o_unit(unit)
    );

    // output register: targets and units are loaded with out_load; tvalid rises via r_pend, then r_ovalid
    logic r_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_pend <= cmd.out_load;
            if (r_pend) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < 3; k++) m_axis_tdata[32*k +: 32] = tgt[k];
        for (int k = 0; k < 9; k++) m_axis_tdata[96 + UW*k +: UW] = unit[k];
    end
    assign m_axis_tvalid = r_ovalid;
endmodule
